@@ design/mt_pkg.sv @@
// Shared types and constants of the MT19937 generator.
package mt_pkg;

   localparam int STATE_WORDS  = 624;
   localparam int TWIST_OFFSET = 397;
   localparam int ADDR_W       = $clog2(STATE_WORDS + 2);
   localparam int WORD_W       = 32;

   localparam logic [ADDR_W-1:0] LAST_IDX     = ADDR_W'(STATE_WORDS - 1);
   localparam logic [ADDR_W-1:0] TWIST_IDX    = ADDR_W'(STATE_WORDS);
   localparam logic [ADDR_W-1:0] NOT_INIT_IDX = ADDR_W'(STATE_WORDS + 1);
   localparam logic [ADDR_W-1:0] FAR_SPLIT    = ADDR_W'(STATE_WORDS - TWIST_OFFSET);
   localparam logic [ADDR_W-1:0] FAR_UP       = ADDR_W'(TWIST_OFFSET);

   localparam logic [WORD_W-1:0] SEED_RESET = 32'd5489;
   localparam logic [WORD_W-1:0] SEED_MULT  = 32'd1812433253;
   localparam logic [WORD_W-1:0] MT_MATRIX  = 32'h9908b0df;
   localparam logic [WORD_W-1:0] MT_UPPER   = 32'h80000000;
   localparam logic [WORD_W-1:0] MT_LOWER   = 32'h7fffffff;
   localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9d2c5680;
   localparam logic [WORD_W-1:0] TEMPER_C   = 32'hefc60000;

   typedef enum logic [1:0] {
      OP_SEED_MUL,
      OP_SEED_ADD,
      OP_TWIST,
      OP_TEMPER
   } op_type;

   typedef struct packed {
      logic               en;
      op_type             op;
      logic [WORD_W-1:0]  a;
      logic [WORD_W-1:0]  b;
      logic [WORD_W-1:0]  c;
      logic [ADDR_W-1:0]  idx;
   } unit_req_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED_START,
      ST_SEED_ADD,
      ST_SEED_WR,
      ST_TW_PRIME,
      ST_TW_CUR,
      ST_TW_NXT,
      ST_TW_CALC,
      ST_TW_WR,
      ST_DRAW_RD,
      ST_DRAW_TEMP,
      ST_DRAW_OUT
   } state_type;

endpackage

@@ design/mt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 624
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/mt_word_unit.sv @@
// Shared word unit: seed multiply, seed add, twist and tempering, result registered.
module mt_word_unit
   import mt_pkg::*;
(
   input  logic               clock,
   input  unit_req_type       unit_req,
   output logic [WORD_W-1:0]  result
);

   logic [WORD_W-1:0] result_ff;
   logic [WORD_W-1:0] result_in;
   logic [WORD_W-1:0] mixed;
   logic [WORD_W-1:0] y_tw;
   logic [WORD_W-1:0] t1, t2, t3, t4;

   always_comb begin
      mixed = unit_req.a ^ (unit_req.a >> 30);
      y_tw  = (unit_req.a & MT_UPPER) | (unit_req.b & MT_LOWER);
      t1    = unit_req.a ^ (unit_req.a >> 11);
      t2    = t1 ^ ((t1 << 7) & TEMPER_B);
      t3    = t2 ^ ((t2 << 15) & TEMPER_C);
      t4    = t3 ^ (t3 >> 18);
      unique case (unit_req.op)
         OP_SEED_MUL: result_in = SEED_MULT * mixed;
         OP_SEED_ADD: result_in = unit_req.a + WORD_W'(unit_req.idx);
         OP_TWIST:    result_in = unit_req.c ^ (y_tw >> 1) ^ (y_tw[0] ? MT_MATRIX : '0);
         OP_TEMPER:   result_in = unit_req.b[0] ? (t4 >> 1) : t4;
         default:     result_in = unit_req.a;
      endcase
   end

   always_ff @(posedge clock) begin
      if (unit_req.en) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

@@ design/mersenne_twister_generator.sv @@
// MT19937 generator top level: sequencer, state table and output register.
//
// Each item on the req_ channel is one draw; req_tdata[0] is narrow, which
// shifts the tempered word right by one. The rsp_ channel returns one
// 32-bit word per item, in order. csr_wr_en/csr_wr_data load the seed and
// force the table to be rebuilt on the next draw; write it only while idle.
//
// One item is in flight at a time; req_tready is high only when idle.
// A draw from a ready table passes the read, temper and output states before
// rsp_tvalid rises; the block is ready again when the result is loaded, so a
// new item is accepted only after the last one has been fully drawn.
// Once every 624 draws the table is twisted first, one word at a time through
// the single read port of the table RAM. The first draw after reset or a seed
// write also seeds the table, one word at a time through the shared multiplier,
// before the twist.
// Reset restores seed 5489 and marks the table unseeded; no clearing pass
// is run. If rsp_tready is low, the result waits in the output register
// and the next draw holds in its output state until it is taken.
module mersenne_twister_generator
   import mt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [0] narrow, [7:1] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [31:0] random_value
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data   // seed
);

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  k_ff, k_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [WORD_W-1:0]  seed_ff;
   logic [WORD_W-1:0]  cur_ff, cur_in;
   logic [WORD_W-1:0]  nxt_ff, nxt_in;
   logic               narrow_ff, narrow_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  rsp_data_ff, rsp_data_in;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [WORD_W-1:0]  wr_data;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [WORD_W-1:0]  rd_data;
   unit_req_type       unit_req;
   logic [WORD_W-1:0]  unit_result;
   logic [ADDR_W-1:0]  k_plus;
   logic [ADDR_W-1:0]  far_addr;

   mt_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STATE_WORDS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mt_word_unit u_unit (
      .clock    (clock),
      .unit_req (unit_req),
      .result   (unit_result)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign k_plus   = k_ff + ADDR_W'(1);
   // in-place twist: far word wraps into already updated entries
   assign far_addr = (k_ff < FAR_SPLIT) ? (k_ff + FAR_UP) : (k_ff - FAR_SPLIT);

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      idx_in       = idx_ff;
      cur_in       = cur_ff;
      nxt_in       = nxt_ff;
      narrow_in    = narrow_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = k_ff;
      wr_data      = unit_result;
      rd_en        = 1'b0;
      rd_addr      = k_ff;
      unit_req     = '{en: 1'b0, op: OP_SEED_MUL, a: unit_result, b: nxt_ff,
                       c: rd_data, idx: k_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               narrow_in = req_tdata[0];
               if (idx_ff == NOT_INIT_IDX) begin
                  state_in = ST_SEED_START;
               end else if (idx_ff == TWIST_IDX) begin
                  state_in = ST_TW_PRIME;
               end else begin
                  state_in = ST_DRAW_RD;
               end
            end
         end
         ST_SEED_START: begin
            wr_en        = 1'b1;
            wr_addr      = '0;
            wr_data      = seed_ff;
            unit_req.en  = 1'b1;
            unit_req.op  = OP_SEED_MUL;
            unit_req.a   = seed_ff;
            k_in         = ADDR_W'(1);
            state_in     = ST_SEED_ADD;
         end
         ST_SEED_ADD: begin
            unit_req.en = 1'b1;
            unit_req.op = OP_SEED_ADD;
            state_in    = ST_SEED_WR;
         end
         ST_SEED_WR: begin
            wr_en       = 1'b1;
            unit_req.en = 1'b1;
            unit_req.op = OP_SEED_MUL;
            if (k_ff == LAST_IDX) begin
               state_in = ST_TW_PRIME;
            end else begin
               k_in     = k_plus;
               state_in = ST_SEED_ADD;
            end
         end
         ST_TW_PRIME: begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            k_in     = '0;
            state_in = ST_TW_CUR;
         end
         ST_TW_CUR: begin
            cur_in   = rd_data;
            rd_en    = 1'b1;
            rd_addr  = ADDR_W'(1);
            state_in = ST_TW_NXT;
         end
         ST_TW_NXT: begin
            nxt_in   = rd_data;
            rd_en    = 1'b1;
            rd_addr  = far_addr;
            state_in = ST_TW_CALC;
         end
         ST_TW_CALC: begin
            unit_req.en = 1'b1;
            unit_req.op = OP_TWIST;
            unit_req.a  = cur_ff;
            unit_req.b  = nxt_ff;
            unit_req.c  = rd_data;
            state_in    = ST_TW_WR;
         end
         ST_TW_WR: begin
            wr_en  = 1'b1;
            cur_in = nxt_ff;
            if (k_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = ST_DRAW_RD;
            end else begin
               k_in     = k_plus;
               rd_en    = 1'b1;
               // last word's successor is entry zero, already twisted
               rd_addr  = (k_plus == LAST_IDX) ? '0 : (k_plus + ADDR_W'(1));
               state_in = ST_TW_NXT;
            end
         end
         ST_DRAW_RD: begin
            rd_en    = 1'b1;
            rd_addr  = idx_ff;
            state_in = ST_DRAW_TEMP;
         end
         ST_DRAW_TEMP: begin
            unit_req.en = 1'b1;
            unit_req.op = OP_TEMPER;
            unit_req.a  = rd_data;
            unit_req.b  = {{(WORD_W-1){1'b0}}, narrow_ff};
            idx_in      = idx_ff + ADDR_W'(1);
            state_in    = ST_DRAW_OUT;
         end
         ST_DRAW_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = unit_result;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         idx_ff       <= NOT_INIT_IDX;
         seed_ff      <= SEED_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         idx_ff       <= csr_wr_en ? NOT_INIT_IDX : idx_in;
         if (csr_wr_en) begin
            seed_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      nxt_ff      <= nxt_in;
      narrow_ff   <= narrow_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("block still ready after accepting an item");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_SEED_START || state_ff == ST_SEED_WR ||
                 state_ff == ST_TW_WR))
      else $error("table write outside seeding or twisting");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (idx_ff <= NOT_INIT_IDX) && (k_ff <= LAST_IDX))
      else $error("table index out of range");

   a_draw_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAW_RD |-> idx_ff <= LAST_IDX)
      else $error("draw from an unprepared table");
`endif

endmodule
